@@ rtl/core/t8c_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t8c_pkg
// types, opcodes and sequencer states shared by the tiny register processor
// ----------------------------------------------------------------------------
package t8c_pkg;

	localparam int MEM_WORDS_DEF = 256;
	localparam int REG_COUNT_DEF = 8;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  load_addr;
		logic [31:0] load_word;
	} in_req_t;

	typedef struct packed {
		logic       print_valid;
		logic       print_as_char;
		logic [7:0] print_value;
		logic       halted;
		logic [1:0] fault;
		logic [7:0] next_pc;
	} out_req_t;

	localparam logic ITEM_LOAD = 1'b0;
	localparam logic ITEM_STEP = 1'b1;

	localparam logic [1:0] FAULT_NONE   = 2'd0;
	localparam logic [1:0] FAULT_OPCODE = 2'd1;
	localparam logic [1:0] FAULT_DIV0   = 2'd2;

	localparam logic [7:0] OP_QUIT   = 8'd0;
	localparam logic [7:0] OP_PRN    = 8'd2;
	localparam logic [7:0] OP_PRNI   = 8'd3;
	localparam logic [7:0] OP_PRC    = 8'd4;
	localparam logic [7:0] OP_PRCI   = 8'd5;
	localparam logic [7:0] OP_LDR    = 8'd32;
	localparam logic [7:0] OP_LDA    = 8'd33;
	localparam logic [7:0] OP_STR    = 8'd34;
	localparam logic [7:0] OP_STRI   = 8'd35;
	localparam logic [7:0] OP_STA    = 8'd36;
	localparam logic [7:0] OP_MOVM   = 8'd37;
	localparam logic [7:0] OP_ADD    = 8'd64;
	localparam logic [7:0] OP_ADDI   = 8'd65;
	localparam logic [7:0] OP_SUB    = 8'd66;
	localparam logic [7:0] OP_SUBI   = 8'd67;
	localparam logic [7:0] OP_MUL    = 8'd68;
	localparam logic [7:0] OP_MULI   = 8'd69;
	localparam logic [7:0] OP_DIV    = 8'd72;
	localparam logic [7:0] OP_DIVI   = 8'd73;
	localparam logic [7:0] OP_MOD    = 8'd80;
	localparam logic [7:0] OP_MODI   = 8'd81;
	localparam logic [7:0] OP_JMP    = 8'd128;
	localparam logic [7:0] OP_BEQ    = 8'd130;
	localparam logic [7:0] OP_BEQI   = 8'd131;
	localparam logic [7:0] OP_BLT    = 8'd132;
	localparam logic [7:0] OP_BLTI   = 8'd133;
	localparam logic [7:0] OP_BLE    = 8'd134;
	localparam logic [7:0] OP_BLEI   = 8'd135;
	localparam logic [7:0] OP_BGT    = 8'd136;
	localparam logic [7:0] OP_BGTI   = 8'd137;
	localparam logic [7:0] OP_BGE    = 8'd138;
	localparam logic [7:0] OP_BGEI   = 8'd139;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_MEMRD,
		ST_DIV,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_op_t;

endpackage

@@ rtl/core/t8c_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t8c_divider
// restoring 8-bit unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module t8c_divider (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] dividend,
	input  logic [7:0] divisor,
	output logic       busy,
	output logic [7:0] quotient,
	output logic [7:0] remainder
);
	import t8c_pkg::*;

	logic [3:0] count_q;
	logic [7:0] quo_q;
	logic [7:0] rem_q;
	logic [7:0] dvs_q;
	logic [8:0] trial;
	logic [8:0] diff;

	assign trial = {rem_q, quo_q[7]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= 4'd8;
		end else if (count_q != '0) begin
			count_q <= count_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (count_q != '0) begin
			if (!diff[8]) begin
				rem_q <= diff[7:0];
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= trial[7:0];
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	assign busy      = (count_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ rtl/core/tiny_8bit_register_cpu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_8bit_register_cpu
// 8-bit register processor with a 256 x 32 program and data memory
// ----------------------------------------------------------------------------
// requests arrive on in_valid/in_stall as in_req_t. a load request writes one
// memory word; a step request fetches, decodes and runs one instruction.
// every request gives exactly one result on out_valid/out_stall as out_req_t.
// a load, or a step while halted, goes straight to the done state; a step
// adds a memory read state when it reads memory, and a divide state on the
// bit-serial divider for divide or modulo by a nonzero value. one request is
// worked on at a time: in_stall is high from acceptance until the result
// register is free again. the memory takes one access at a time, read data
// registered. while the receiver stalls, the result is held and no new
// request is taken. reset clears the registers, the program counter, the
// halt flag and the control; memory is undefined until loaded.
// ----------------------------------------------------------------------------
module tiny_8bit_register_cpu #(
	parameter int MEM_WORDS = t8c_pkg::MEM_WORDS_DEF,
	parameter int REG_COUNT = t8c_pkg::REG_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  t8c_pkg::in_req_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output t8c_pkg::out_req_t out_data
);
	import t8c_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam int RW = $clog2(REG_COUNT);

	state_t state_q, state_d;

	logic [31:0] mem [MEM_WORDS];
	logic [31:0] rdata_q;
	logic [7:0]  regs_q [REG_COUNT];
	logic [7:0]  pc_q;
	logic        halt_q;
	in_req_t     req_q;
	out_req_t    res_q;
	logic        out_valid_q;

	logic [7:0] op_q, a_q, b_q, c_q, x_q, y_q;

	// divider
	logic       div_start;
	logic       div_busy;
	logic [7:0] div_quo, div_rem;

	t8c_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (x_q),
		.divisor   (y_q),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	function automatic logic [7:0] rd_reg(input logic [7:0] sel, input logic [7:0] r [REG_COUNT]);
		logic [RW-1:0] s;
		s = sel[RW-1:0];
		return (s == '0) ? 8'd0 : r[s];
	endfunction

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || out_valid_q;

	// register selected by operand a
	logic [7:0] ra_val;
	assign ra_val = rd_reg(a_q, regs_q);

	// memory control
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	// decode of fetched word
	logic [7:0] w_op, w_a, w_b, w_c;
	assign w_op = rdata_q[7:0];
	assign w_a  = rdata_q[15:8];
	assign w_b  = rdata_q[23:16];
	assign w_c  = rdata_q[31:24];

	// shared alu
	alu_op_t    alu_op;
	logic [7:0] alu_res;
	logic [15:0] prod;
	assign prod = x_q * y_q;
	always_comb begin
		unique case (alu_op)
			ALU_ADD: alu_res = x_q + y_q;
			ALU_SUB: alu_res = x_q - y_q;
			ALU_MUL: alu_res = prod[7:0];
			default: alu_res = x_q + y_q;
		endcase
	end

	logic is_arith, is_div, is_branch, known;
	always_comb begin
		is_arith  = (op_q >= OP_ADD && op_q <= OP_MULI);
		is_div    = (op_q == OP_DIV) || (op_q == OP_DIVI) ||
		            (op_q == OP_MOD) || (op_q == OP_MODI);
		is_branch = (op_q >= OP_BEQ && op_q <= OP_BGEI);
		known     = (op_q == OP_QUIT) || (op_q >= OP_PRN && op_q <= OP_PRCI) ||
		            (op_q >= OP_LDR && op_q <= OP_MOVM) || is_arith || is_div ||
		            (op_q == OP_JMP) || is_branch;
		unique case (op_q[2:1])
			2'd0:    alu_op = ALU_ADD;
			2'd1:    alu_op = ALU_SUB;
			default: alu_op = ALU_MUL;
		endcase
	end

	logic take;
	always_comb begin
		unique case (op_q[3:1])
			3'd0:    take = 1'b1;
			3'd1:    take = (x_q == y_q);
			3'd2:    take = (x_q < y_q);
			3'd3:    take = (x_q <= y_q);
			3'd4:    take = (x_q > y_q);
			3'd5:    take = (x_q >= y_q);
			default: take = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.opcode == ITEM_LOAD || halt_q)
						state_d = ST_DONE;
					else
						state_d = ST_FETCH;
				end
			end
			ST_FETCH:  state_d = ST_DECODE;
			ST_DECODE: begin
				if (op_q == OP_LDR || op_q == OP_LDA || op_q == OP_MOVM)
					state_d = ST_MEMRD;
				else if (is_div && y_q != 8'd0)
					state_d = ST_DIV;
				else
					state_d = ST_EXEC;
			end
			ST_MEMRD:  state_d = ST_EXEC;
			ST_DIV:    if (!div_busy) state_d = ST_EXEC;
			ST_EXEC:   state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = pc_q[AW-1:0];
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_data.opcode == ITEM_LOAD) begin
					mem_we    = 1'b1;
					mem_waddr = in_data.load_addr[AW-1:0];
					mem_wdata = in_data.load_word;
				end else if (accept) begin
					mem_re = 1'b1;
				end
			end
			ST_DECODE: begin
				mem_re = 1'b1;
				if (op_q == OP_LDR)
					mem_raddr = x_q[AW-1:0];
				else
					mem_raddr = b_q[AW-1:0];
				div_start = is_div && (y_q != 8'd0);
			end
			ST_EXEC: begin
				unique case (op_q)
					OP_STR: begin
						mem_we    = 1'b1;
						mem_waddr = ra_val[AW-1:0];
						mem_wdata = {24'd0, x_q};
					end
					OP_STRI: begin
						mem_we    = 1'b1;
						mem_waddr = ra_val[AW-1:0];
						mem_wdata = {24'd0, b_q};
					end
					OP_STA: begin
						mem_we    = 1'b1;
						mem_waddr = a_q[AW-1:0];
						mem_wdata = {24'd0, x_q};
					end
					OP_MOVM: begin
						mem_we    = 1'b1;
						mem_waddr = a_q[AW-1:0];
						mem_wdata = rdata_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < REG_COUNT; i++)
				regs_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q <= in_data;
						res_q <= '0;
					end
				end
				ST_FETCH: ;
				ST_DECODE: pc_q <= pc_q + 8'd1;
				ST_EXEC: begin
					if (op_q == OP_QUIT) begin
						halt_q <= 1'b1;
					end else if (op_q == OP_PRN || op_q == OP_PRC) begin
						res_q.print_valid   <= 1'b1;
						res_q.print_as_char <= (op_q == OP_PRC);
						res_q.print_value   <= ra_val;
					end else if (op_q == OP_PRNI || op_q == OP_PRCI) begin
						res_q.print_valid   <= 1'b1;
						res_q.print_as_char <= (op_q == OP_PRCI);
						res_q.print_value   <= a_q;
					end else if (op_q == OP_LDR || op_q == OP_LDA) begin
						if (a_q[RW-1:0] != '0)
							regs_q[a_q[RW-1:0]] <= rdata_q[7:0];
					end else if (is_arith) begin
						if (a_q[RW-1:0] != '0)
							regs_q[a_q[RW-1:0]] <= alu_res;
					end else if (is_div) begin
						if (y_q == 8'd0) begin
							res_q.fault <= FAULT_DIV0;
							halt_q      <= 1'b1;
						end else if (a_q[RW-1:0] != '0) begin
							regs_q[a_q[RW-1:0]] <= (op_q < OP_MOD) ? div_quo : div_rem;
						end
					end else if (op_q == OP_JMP || is_branch) begin
						if (take)
							pc_q <= a_q;
					end else if (!known) begin
						res_q.fault <= FAULT_OPCODE;
						halt_q      <= 1'b1;
					end
				end
				ST_DONE: begin
					res_q.halted  <= halt_q;
					res_q.next_pc <= pc_q;
					out_valid_q   <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// operand latch after fetch
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			op_q <= w_op;
			a_q  <= w_a;
			b_q  <= w_b;
			c_q  <= w_c;
			x_q  <= rd_reg(w_b, regs_q);
			y_q  <= w_op[0] ? w_c : rd_reg(w_c, regs_q);
		end
	end

	assign out_valid = out_valid_q;
	always_comb begin
		out_data         = res_q;
		out_data.halted  = res_q.halted;
		out_data.next_pc = res_q.next_pc;
	end

	// c operand is kept for traceability of the decoded word
	logic unused_c;
	assign unused_c = ^{c_q, req_q};

endmodule

@@ rtl/core/t8c_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t8c_checker
// port-level checks of the tiny register processor
// ----------------------------------------------------------------------------
module t8c_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input t8c_pkg::in_req_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input t8c_pkg::out_req_t out_data
);
	import t8c_pkg::*;

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// no request taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");

	// after a request is taken the block is busy next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after request");

	// a fault always comes with the halt flag
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fault != FAULT_NONE |-> out_data.halted)
		else $error("fault without halt");

	// nothing printed means zero print fields
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.print_valid |->
		!out_data.print_as_char && out_data.print_value == 8'd0)
		else $error("stray print fields");

endmodule

bind tiny_8bit_register_cpu t8c_checker u_t8c_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
